// ===== rtl/swrr_pkg.sv =====
// Shared widths, opcodes and constants of the smooth weighted round-robin selector.
`default_nettype none
package swrr_pkg;

  localparam int OPCODE_W = 2;
  localparam int NODE_W   = 4;
  localparam int WEIGHT_W = 8;
  localparam int MASK_W   = 16;
  // sum of at most sixteen 8-bit weights
  localparam int TOTAL_W  = 12;

  localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SELECT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_REPORT = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/swrr_in_if.sv =====
// Request channel of the smooth weighted round-robin selector.
`default_nettype none
interface swrr_in_if;
  logic                            valid;
  logic                            ready;
  logic [swrr_pkg::OPCODE_W-1:0]   opcode;
  logic [swrr_pkg::NODE_W-1:0]     node;
  logic [swrr_pkg::WEIGHT_W-1:0]   weight;
  logic                            success;
  logic [swrr_pkg::MASK_W-1:0]     eligible_mask;

  modport source (output valid, opcode, node, weight, success, eligible_mask, input ready);
  modport sink   (input valid, opcode, node, weight, success, eligible_mask, output ready);
endinterface
`default_nettype wire

// ===== rtl/swrr_out_if.sv =====
// Result channel of the smooth weighted round-robin selector.
`default_nettype none
interface swrr_out_if;
  logic                        valid;
  logic                        ready;
  logic [swrr_pkg::NODE_W-1:0] chosen;
  logic                        ok;

  modport source (output valid, chosen, ok, input ready);
  modport sink   (input valid, chosen, ok, output ready);
endinterface
`default_nettype wire

// ===== rtl/smooth_weighted_round_robin_core.sv =====
// Top level of the smooth weighted round-robin selector: control, table memory and result register.
//
// Each slot's configured weight, effective weight and signed current weight share one word of
// a table RAM; the loaded flags sit in flip-flops and clear at reset. One request is handled at
// a time. A select with any eligible loaded slot walks the first min(NODES,16) slots through the
// RAM's single read port, one slot per cycle, writing each updated current weight back as it
// goes, then writes back the winner in S_FIN. A select with no eligible slot, a load, an unused
// opcode or any other report goes straight to S_PUSH, while a failure report on a loaded slot
// first reads and rewrites the effective weight in S_RPT. The next request is taken once the
// result has moved into the output register, which then holds it until it is taken.
`default_nettype none
module smooth_weighted_round_robin_core #(
  parameter int NODES        = 16,
  parameter int CURRENT_BITS = 24
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  swrr_in_if.sink     in_req,
  swrr_out_if.source  out_res
);

  localparam int IW    = $clog2(NODES);
  localparam int WALK  = (NODES < 16) ? NODES : 16;
  localparam int MW    = (NODES > swrr_pkg::MASK_W) ? NODES : swrr_pkg::MASK_W;
  localparam int CB    = CURRENT_BITS;
  localparam int WW    = swrr_pkg::WEIGHT_W;
  localparam int DW    = 2 * WW + CB;
  localparam logic [IW-1:0] LAST = IW'(WALK - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_RPT  = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [NODES-1:0]        loaded_r, loaded_nxt;
  logic [NODES-1:0]        elig_r, elig_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic [IW-1:0]           addr_r, addr_nxt;
  logic                    any_r, any_nxt;
  logic signed [CB-1:0]    best_r, best_nxt;
  logic [swrr_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic [IW-1:0]           win_idx_r, win_idx_nxt;
  logic [WW-1:0]           win_cfg_r, win_cfg_nxt;
  logic [WW-1:0]           win_eff_r, win_eff_nxt;
  logic signed [CB-1:0]    win_cur_r, win_cur_nxt;
  logic [swrr_pkg::NODE_W-1:0] res_chosen_r, res_chosen_nxt;
  logic                    res_ok_r, res_ok_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [swrr_pkg::NODE_W-1:0] out_chosen_r;
  logic                    out_ok_r;

  logic                    ram_we;
  logic [IW-1:0]           ram_waddr, ram_raddr;
  logic [DW-1:0]           ram_wdata, ram_rdata;

  logic                    in_acc;
  logic                    out_free;
  logic [IW-1:0]           in_addr;
  logic                    in_range;
  logic [MW-1:0]           mask_ext;
  logic [WW-1:0]           rd_cfg, rd_eff, eff_dec;
  logic signed [CB-1:0]    rd_cur, cur_add, cur_sub;
  logic [CB:0]             sum_w, diff_w;

  swrr_ram #(.WIDTH(DW), .DEPTH(NODES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_req.ready   = (state_r == S_IDLE);
  assign in_acc         = in_req.valid && in_req.ready;
  assign out_free       = !out_valid_r || out_res.ready;
  assign out_res.valid  = out_valid_r;
  assign out_res.chosen = out_chosen_r;
  assign out_res.ok     = out_ok_r;

  assign in_addr  = IW'(in_req.node);
  assign in_range = int'(in_req.node) < NODES;
  assign mask_ext = MW'(in_req.eligible_mask);

  assign rd_cfg = ram_rdata[DW-1 -: WW];
  assign rd_eff = ram_rdata[CB +: WW];
  assign rd_cur = ram_rdata[CB-1:0];

  // saturating add of effective weight, saturating subtract of the walked total
  assign sum_w  = {rd_cur[CB-1], rd_cur} + (CB+1)'(rd_eff);
  assign diff_w = {win_cur_r[CB-1], win_cur_r} - (CB+1)'(total_r);
  assign cur_add = (sum_w[CB] != sum_w[CB-1]) ? {1'b0, {(CB-1){1'b1}}} : sum_w[CB-1:0];
  assign cur_sub = (diff_w[CB] != diff_w[CB-1]) ? {1'b1, {(CB-1){1'b0}}} : diff_w[CB-1:0];
  assign eff_dec = (rd_eff > WW'(2)) ? rd_eff - WW'(1) : WW'(1);

  always_comb begin
    ram_raddr = addr_r;
    if (state_r == S_WALK) begin
      ram_raddr = idx_r + IW'(1);
    end else if (in_req.opcode == swrr_pkg::OP_SELECT) begin
      ram_raddr = '0;
    end else begin
      ram_raddr = in_addr;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    loaded_nxt     = loaded_r;
    elig_nxt       = elig_r;
    idx_nxt        = idx_r;
    addr_nxt       = addr_r;
    any_nxt        = any_r;
    best_nxt       = best_r;
    total_nxt      = total_r;
    win_idx_nxt    = win_idx_r;
    win_cfg_nxt    = win_cfg_r;
    win_eff_nxt    = win_eff_r;
    win_cur_nxt    = win_cur_r;
    res_chosen_nxt = res_chosen_r;
    res_ok_nxt     = res_ok_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    ram_we         = 1'b0;
    ram_waddr      = in_addr;
    ram_wdata      = {in_req.weight, in_req.weight, {CB{1'b0}}};

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_chosen_nxt = '0;
          res_ok_nxt     = 1'b0;
          state_nxt      = S_PUSH;
          case (in_req.opcode)
            swrr_pkg::OP_LOAD: begin
              res_ok_nxt = 1'b1;
              if (in_range) begin
                ram_we              = 1'b1;
                loaded_nxt[in_addr] = 1'b1;
              end
            end
            swrr_pkg::OP_SELECT: begin
              elig_nxt = loaded_r & mask_ext[NODES-1:0];
              if (|elig_nxt) begin
                idx_nxt   = '0;
                any_nxt   = 1'b0;
                best_nxt  = '1;
                total_nxt = '0;
                state_nxt = S_WALK;
              end
            end
            swrr_pkg::OP_REPORT: begin
              if (in_range && loaded_r[in_addr]) begin
                res_ok_nxt = 1'b1;
                addr_nxt   = in_addr;
                if (!in_req.success) begin
                  state_nxt = S_RPT;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        if (elig_r[idx_r]) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r;
          ram_wdata = {rd_cfg, rd_eff, cur_add};
          total_nxt = total_r + swrr_pkg::TOTAL_W'(rd_cfg);
          any_nxt   = 1'b1;
          if (!any_r || (cur_add > best_r)) begin
            win_idx_nxt = idx_r;
            win_cfg_nxt = rd_cfg;
            win_eff_nxt = rd_eff;
            win_cur_nxt = cur_add;
          end
          if (cur_add > best_r) begin
            best_nxt = cur_add;
          end
        end
        idx_nxt = idx_r + IW'(1);
        if (idx_r == LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        ram_we         = 1'b1;
        ram_waddr      = win_idx_r;
        ram_wdata      = {win_cfg_r, win_eff_r, cur_sub};
        res_chosen_nxt = swrr_pkg::NODE_W'(win_idx_r);
        res_ok_nxt     = 1'b1;
        state_nxt      = S_PUSH;
      end
      S_RPT: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        ram_wdata = {rd_cfg, eff_dec, rd_cur};
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elig_r       <= elig_nxt;
    idx_r        <= idx_nxt;
    addr_r       <= addr_nxt;
    any_r        <= any_nxt;
    best_r       <= best_nxt;
    total_r      <= total_nxt;
    win_idx_r    <= win_idx_nxt;
    win_cfg_r    <= win_cfg_nxt;
    win_eff_r    <= win_eff_nxt;
    win_cur_r    <= win_cur_nxt;
    res_chosen_r <= res_chosen_nxt;
    res_ok_r     <= res_ok_nxt;
    if ((state_r == S_PUSH) && out_free) begin
      out_chosen_r <= res_chosen_r;
      out_ok_r     <= res_ok_r;
    end
  end

`ifndef SYNTHESIS
  a_fail_no_chosen: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.ok |-> out_res.chosen == '0)
    else $error("failed request reports a nonzero slot");

  a_fin_has_winner: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |-> any_r)
    else $error("winner write-back without any walked slot");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_req.ready)
    else $error("second request accepted while one is in flight");

  a_load_marks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_req.opcode == swrr_pkg::OP_LOAD && in_range |=> loaded_r[$past(in_addr)])
    else $error("loaded slot not flagged");
`endif

endmodule
`default_nettype wire

// ===== rtl/swrr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module swrr_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== verif/swrr_answer_checker.sv =====
// Request/result monitor that predicts each selector answer and compares it with the block's.
module swrr_answer_checker #(
  parameter int NODES        = 16,
  parameter int CURRENT_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  swrr_in_if   req,
  swrr_out_if  res,
  output int   mismatches,
  output int   waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CUR_HI = (longint'(1) << (CURRENT_BITS - 1)) - 1;
  localparam longint CUR_LO = -CUR_HI - 1;

  typedef struct packed {
    logic [swrr_pkg::NODE_W-1:0] chosen;
    logic                        ok;
  } answer_t;

  logic                          slot_loaded [NODES];
  logic [swrr_pkg::WEIGHT_W-1:0] conf_w      [NODES];
  logic [swrr_pkg::WEIGHT_W-1:0] eff_w       [NODES];
  longint                        cur_w       [NODES];
  answer_t                       pending_answers[$];
  int                            errs = 0;

  assign mismatches = errs;
  initial waiting = 0;

  function automatic longint clamp_cur(longint v);
    if (v > CUR_HI) return CUR_HI;
    if (v < CUR_LO) return CUR_LO;
    return v;
  endfunction

  function automatic void append_answer(answer_t a);
    pending_answers.insert(pending_answers.size(), a);
  endfunction

  // Updates the slot table and returns the answer the request should produce.
  function automatic answer_t predict_answer(logic [swrr_pkg::OPCODE_W-1:0] op,
                                             logic [swrr_pkg::NODE_W-1:0] node,
                                             logic [swrr_pkg::WEIGHT_W-1:0] w, logic succ,
                                             logic [swrr_pkg::MASK_W-1:0] mask);
    answer_t a;
    longint  total;
    longint  best;
    int      win;
    bit      any;
    a     = '0;
    total = 0;
    best  = -1;
    win   = 0;
    any   = 0;
    case (op)
      swrr_pkg::OP_LOAD: begin
        if (int'(node) < NODES) begin
          slot_loaded[node] = 1'b1;
          conf_w[node]      = w;
          eff_w[node]       = w;
          cur_w[node]       = 0;
        end
        a.ok = 1'b1;
      end
      swrr_pkg::OP_SELECT: begin
        for (int i = 0; i < NODES; i++) begin
          if (slot_loaded[i] && i < swrr_pkg::MASK_W && mask[i]) begin
            total += longint'(conf_w[i]);
            cur_w[i] = clamp_cur(cur_w[i] + longint'(eff_w[i]));
            if (!any) win = i;
            any = 1;
            if (cur_w[i] > best) begin
              best = cur_w[i];
              win  = i;
            end
          end
        end
        if (any) begin
          cur_w[win] = clamp_cur(cur_w[win] - total);
          a.chosen   = swrr_pkg::NODE_W'(win);
          a.ok       = 1'b1;
        end
      end
      swrr_pkg::OP_REPORT: begin
        if (int'(node) < NODES && slot_loaded[node]) begin
          a.ok = 1'b1;
          if (!succ) begin
            eff_w[node] = (eff_w[node] > 2) ? eff_w[node] - 1'b1 : swrr_pkg::WEIGHT_W'(1);
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++) begin
        slot_loaded[i] = 1'b0;
        conf_w[i]      = '0;
        eff_w[i]       = '0;
        cur_w[i]       = 0;
      end
      pending_answers.delete();
    end else begin
      if (req.valid && req.ready)
        append_answer(predict_answer(req.opcode, req.node, req.weight,
                                     req.success, req.eligible_mask));
      if (res.valid && res.ready) begin
        if (pending_answers.size() == 0) begin
          errs++;
          $display("%0t: unexpected result, expected none, got chosen=%0d ok=%0d",
                   $time, res.chosen, res.ok);
        end else begin
          exp_a = pending_answers.pop_front();
          if (res.chosen !== exp_a.chosen) begin
            errs++;
            $display("%0t: chosen mismatch, expected %0d, got %0d",
                     $time, exp_a.chosen, res.chosen);
          end
          if (res.ok !== exp_a.ok) begin
            errs++;
            $display("%0t: ok mismatch, expected %0d, got %0d", $time, exp_a.ok, res.ok);
          end
        end
      end
    end
    waiting <= pending_answers.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the selector testbench: clock, reset, request stimulus, result stalls and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [swrr_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_ITEMS  = 700;
  localparam int PHASES        = 4;
  localparam int DRAIN_CYCLES  = 40;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   mismatches;
  int   waiting;
  bit   src_idle_on   = 1'b0;
  bit   sink_stall_on = 1'b0;
  int   hold_left     = 0;
  int   pick;
  int   idle_cycles   = 0;

  always #5 clk = ~clk;

  swrr_in_if  req_ch();
  swrr_out_if res_ch();

  smooth_weighted_round_robin_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_res (res_ch)
  );

  swrr_answer_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req_ch),
    .res        (res_ch),
    .mismatches (mismatches),
    .waiting    (waiting)
  );

  initial begin
    req_ch.valid         = 1'b0;
    req_ch.opcode        = swrr_pkg::OP_LOAD;
    req_ch.node          = '0;
    req_ch.weight        = '0;
    req_ch.success       = 1'b0;
    req_ch.eligible_mask = '0;
    res_ch.ready         = 1'b0;
  end

  // result-side stalls: mostly short, a few long
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
    end else if (!sink_stall_on) begin
      res_ch.ready = 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        res_ch.ready = 1'b1;
        hold_left    = $urandom_range(0, 4);
      end else if (pick < 95) begin
        res_ch.ready = 1'b0;
        hold_left    = $urandom_range(0, 2);
      end else begin
        res_ch.ready = 1'b0;
        hold_left    = $urandom_range(10, 40);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (!src_idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_req(logic [swrr_pkg::OPCODE_W-1:0] op, logic [swrr_pkg::NODE_W-1:0] node,
                          logic [swrr_pkg::WEIGHT_W-1:0] w, logic succ,
                          logic [swrr_pkg::MASK_W-1:0] mask);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.opcode        = op;
    req_ch.node          = node;
    req_ch.weight        = w;
    req_ch.success       = succ;
    req_ch.eligible_mask = mask;
    req_ch.valid         = 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid = 1'b0;
    while (waiting != 0) @(negedge clk);
  endtask

  function automatic logic [swrr_pkg::WEIGHT_W-1:0] rand_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 35) return swrr_pkg::WEIGHT_W'($urandom_range(1, 3));
    return swrr_pkg::WEIGHT_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [swrr_pkg::MASK_W-1:0] rand_mask();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return '1;
    if (r < 25) return '0;
    if (r < 40) return swrr_pkg::MASK_W'(1) << $urandom_range(0, swrr_pkg::MASK_W - 1);
    return swrr_pkg::MASK_W'($urandom_range(0, 65535));
  endfunction

  task automatic send_random();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12)
      send_req(swrr_pkg::OP_LOAD, swrr_pkg::NODE_W'($urandom_range(0, 15)), rand_weight(),
               1'($urandom), swrr_pkg::MASK_W'($urandom));
    else if (r < 70)
      send_req(swrr_pkg::OP_SELECT, swrr_pkg::NODE_W'($urandom_range(0, 15)),
               swrr_pkg::WEIGHT_W'($urandom), 1'($urandom), rand_mask());
    else if (r < 95)
      send_req(swrr_pkg::OP_REPORT, swrr_pkg::NODE_W'($urandom_range(0, 15)),
               swrr_pkg::WEIGHT_W'($urandom), 1'($urandom), swrr_pkg::MASK_W'($urandom));
    else
      send_req(OP_UNUSED, swrr_pkg::NODE_W'($urandom), swrr_pkg::WEIGHT_W'($urandom),
               1'($urandom), swrr_pkg::MASK_W'($urandom));
  endtask

  // watchdog: ends the run when no request or result moves for too long
  initial begin
    @(posedge rst_n);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
    end
    $display("** smooth_weighted_round_robin_core: FAILED **");
    $finish;
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty table, extremes, floor of effective weight, no winner above -1
    send_req(swrr_pkg::OP_REPORT, 4'd3, 8'd0, 1'b0, 16'h0000);
    send_req(swrr_pkg::OP_SELECT, 4'd0, 8'd0, 1'b0, 16'hFFFF);
    send_req(OP_UNUSED, 4'd15, 8'd255, 1'b1, 16'hFFFF);
    send_req(swrr_pkg::OP_LOAD, 4'd0, 8'd0, 1'b0, 16'h0000);
    send_req(swrr_pkg::OP_LOAD, 4'd15, 8'd255, 1'b1, 16'hFFFF);
    send_req(swrr_pkg::OP_LOAD, 4'd7, 8'd1, 1'b0, 16'h0000);
    send_req(swrr_pkg::OP_LOAD, 4'd3, 8'd128, 1'b0, 16'h0000);
    send_req(swrr_pkg::OP_SELECT, 4'd0, 8'd0, 1'b0, 16'h0000);
    send_req(swrr_pkg::OP_SELECT, 4'd0, 8'd0, 1'b0, 16'h8000);
    send_req(swrr_pkg::OP_SELECT, 4'd15, 8'd255, 1'b1, 16'hFFFF);
    send_req(swrr_pkg::OP_SELECT, 4'd0, 8'd0, 1'b0, 16'hFFFF);
    send_req(swrr_pkg::OP_SELECT, 4'd0, 8'd0, 1'b0, 16'hFFFF);
    send_req(swrr_pkg::OP_REPORT, 4'd0, 8'd0, 1'b0, 16'h0000);
    send_req(swrr_pkg::OP_REPORT, 4'd15, 8'd0, 1'b1, 16'h0000);
    send_req(swrr_pkg::OP_REPORT, 4'd7, 8'd0, 1'b0, 16'h0000);
    send_req(swrr_pkg::OP_SELECT, 4'd0, 8'd0, 1'b0, 16'h0001);
    send_req(swrr_pkg::OP_LOAD, 4'd9, 8'd2, 1'b0, 16'h0000);
    send_req(swrr_pkg::OP_LOAD, 4'd10, 8'd2, 1'b0, 16'h0000);
    send_req(swrr_pkg::OP_REPORT, 4'd9, 8'd0, 1'b0, 16'h0000);
    send_req(swrr_pkg::OP_REPORT, 4'd10, 8'd0, 1'b0, 16'h0000);
    repeat (3) send_req(swrr_pkg::OP_SELECT, 4'd0, 8'd0, 1'b0, 16'h0600);
    send_req(swrr_pkg::OP_LOAD, 4'd15, 8'd200, 1'b0, 16'h0000);
    send_req(swrr_pkg::OP_SELECT, 4'd0, 8'd0, 1'b0, 16'h0002);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      src_idle_on   = (ph != 0);
      sink_stall_on = (ph == 1 || ph == 3);
      repeat (RANDOM_ITEMS / PHASES) send_random();
      wait_drained();
    end

    src_idle_on   = 1'b0;
    sink_stall_on = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && waiting == 0)
      $display("** smooth_weighted_round_robin_core: PASSED **");
    else
      $display("** smooth_weighted_round_robin_core: FAILED **");
    $finish;
  end

endmodule
